// ===== hw/rtl/psvs_pkg.sv =====
// ----------------------------------------------------------------------------
// psvs_pkg
// Shared types, codes and helpers of the prioritized source value store.
// ----------------------------------------------------------------------------
package psvs_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int NUM_SOURCES   = 8;

	localparam int VALUE_W  = 32;
	localparam int SRC_W    = 3;
	localparam int TIME_W   = 32;
	localparam int CLASS_W  = 2;
	localparam int RANK_W   = 4;
	localparam int SLOT_W   = 4;
	localparam int ELAPSED_W = 16;
	localparam int REQ_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 32;
	// Slot index widened far enough to hold any slot count up to 256.
	localparam int SLOT_EXT_W = 9;

	localparam logic [REQ_W-1:0] REQ_PUBLISH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVALID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANKS   = 2'd2;

	localparam logic [CLASS_W-1:0] CLASS_FRESH   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_STALE   = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd2;

	localparam logic [RANK_W-1:0] RANK_UNLISTED = 4'd8;

	localparam logic [CFG_W-1:0] STALE_RESET   = 32'd5000;
	localparam logic [CFG_W-1:0] INVALID_RESET = 32'd30000;
	localparam logic [CFG_W-1:0] RANKS_RESET   = 32'h8888_8888;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [SRC_W-1:0]          writer;
		logic [TIME_W-1:0]         stamp;
	} slot_entry_t;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [TIME_W-1:0]  age;
		logic               past_invalid;
	} age_res_t;

	function automatic logic [RANK_W-1:0] rank_of(input logic [CFG_W-1:0] map,
	                                              input logic [SRC_W-1:0] src);
		logic [RANK_W-1:0] r;
		if (5'(src) >= 5'(NUM_SOURCES)) begin
			r = RANK_UNLISTED;
		end else begin
			r = map[{src, 2'b00} +: RANK_W];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/prioritized_source_value_store.sv =====
// ----------------------------------------------------------------------------
// prioritized_source_value_store
// Table of sensor value slots with source ranking and freshness aging.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, kind in tuser (publish, tick, read),
// and each gives exactly one result transfer on m_axis. The cfg channel writes
// the stale limit, the invalid limit and the source rank map.
// A publish or read latches its request, reads the slot memory, then loads the
// age unit's result into the output register. A tick advances the clock and
// walks every slot through the single shared age unit, a memory read and then
// an evaluation per slot, and then gives its result.
// Writing the stale or invalid limit starts the same walk without a result;
// the block takes no request or config write until it ends.
// The slot memory read port is the one resource every step goes through.
// A finished result sits in an output register, so a new request is taken
// while it waits; if the receiver stalls, the next result holds in the age
// stage until the register frees up.
// Reset clears the clock, marks every slot unset and invalid, and loads the
// default limits and rank map. Slot payload memory is not cleared.
// ----------------------------------------------------------------------------
module prioritized_source_value_store
	import psvs_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_axis_tdata, lowest bit up: slot[3:0], source_id[6:4], value[38:7],
	// has_timestamp[39], timestamp_ms[71:40], elapsed_ms[87:72]
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [87:0]          s_axis_tdata,
	// s_axis_tuser: req_type[1:0]
	input  logic [REQ_W-1:0]     s_axis_tuser,
	// m_axis_tdata, lowest bit up: accepted[0], changed[1], read_value[33:2],
	// read_source[36:34], read_freshness[38:37], read_age_ms[70:39],
	// read_set[71]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [71:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RD      = 3'd1;
	localparam logic [2:0] S_EVAL    = 3'd2;
	localparam logic [2:0] S_SW_RD   = 3'd3;
	localparam logic [2:0] S_SW_EVAL = 3'd4;
	localparam logic [2:0] S_SW_OUT  = 3'd5;

	logic [2:0] state_q;

	logic [CFG_W-1:0]  stale_q;
	logic [CFG_W-1:0]  invalid_q;
	logic [CFG_W-1:0]  ranks_q;
	logic [TIME_W-1:0] clock_q;

	logic               valid_q [NUM_SLOTS];
	logic [CLASS_W-1:0] class_q [NUM_SLOTS];

	// Latched request.
	logic [REQ_W-1:0]          req_q;
	logic [IDX_W-1:0]          addr_q;
	logic                      in_range_q;
	logic [SRC_W-1:0]          src_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      has_ts_q;
	logic [TIME_W-1:0]         ts_q;

	// Sweep control.
	logic [IDX_W-1:0] idx_q;
	logic             report_q;
	logic             any_q;

	// Output register.
	logic                      m_valid_q;
	logic                      o_accepted_q;
	logic                      o_changed_q;
	logic signed [VALUE_W-1:0] o_value_q;
	logic [SRC_W-1:0]          o_source_q;
	logic [CLASS_W-1:0]        o_fresh_q;
	logic [TIME_W-1:0]         o_age_q;
	logic                      o_set_q;

	logic                  in_fire;
	logic                  cfg_fire;
	logic                  out_fire;
	logic                  out_free;
	logic                  out_load;
	logic                  sweeping;
	logic [IDX_W-1:0]      sel_idx;
	logic                  sel_valid;
	logic [CLASS_W-1:0]    sel_class;
	slot_entry_t           rd_entry;
	slot_entry_t           wr_entry;
	logic                  ram_we;
	age_res_t              age_res;
	logic                  may_write;
	logic                  pub_ok;
	logic [SLOT_EXT_W-1:0] slot_ext;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = ((state_q == S_EVAL) || (state_q == S_SW_OUT)) && out_free;

	assign cfg_ready     = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;

	assign sweeping  = (state_q == S_SW_RD) || (state_q == S_SW_EVAL);
	assign sel_idx   = sweeping ? idx_q : addr_q;
	assign sel_valid = valid_q[sel_idx];
	assign sel_class = class_q[sel_idx];
	assign slot_ext  = SLOT_EXT_W'(s_axis_tdata[3:0]);

	psvs_slot_ram #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(wr_entry),
		.raddr(sel_idx),
		.rdata(rd_entry)
	);

	psvs_age_unit u_age (
		.clock_ms  (clock_q),
		.stamp     (rd_entry.stamp),
		.set       (sel_valid),
		.stale_ms  (stale_q),
		.invalid_ms(invalid_q),
		.res       (age_res)
	);

	always_comb begin
		may_write = !sel_valid || age_res.past_invalid || (rd_entry.writer == src_q) ||
		            (rank_of(ranks_q, src_q) <= rank_of(ranks_q, rd_entry.writer));
		pub_ok    = in_range_q && may_write;
		ram_we    = (state_q == S_EVAL) && out_free && (req_q == REQ_PUBLISH) && pub_ok;
		wr_entry.value  = value_q;
		wr_entry.writer = src_q;
		wr_entry.stamp  = has_ts_q ? ts_q : clock_q;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q      <= s_axis_tuser;
			addr_q     <= slot_ext[IDX_W-1:0];
			in_range_q <= (slot_ext < SLOT_EXT_W'(NUM_SLOTS));
			src_q      <= s_axis_tdata[6:4];
			value_q    <= s_axis_tdata[38:7];
			has_ts_q   <= s_axis_tdata[39];
			ts_q       <= s_axis_tdata[71:40];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			stale_q      <= STALE_RESET;
			invalid_q    <= INVALID_RESET;
			ranks_q      <= RANKS_RESET;
			clock_q      <= '0;
			idx_q        <= '0;
			report_q     <= 1'b0;
			any_q        <= 1'b0;
			m_valid_q    <= 1'b0;
			o_accepted_q <= 1'b0;
			o_changed_q  <= 1'b0;
			o_value_q    <= '0;
			o_source_q   <= '0;
			o_fresh_q    <= CLASS_FRESH;
			o_age_q      <= '0;
			o_set_q      <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				class_q[i] <= CLASS_INVALID;
			end
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (out_fire) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_fire) begin
						unique case (cfg_index)
							CFG_STALE: begin
								stale_q  <= cfg_data;
								idx_q    <= '0;
								report_q <= 1'b0;
								any_q    <= 1'b0;
								state_q  <= S_SW_RD;
							end
							CFG_INVALID: begin
								invalid_q <= cfg_data;
								idx_q     <= '0;
								report_q  <= 1'b0;
								any_q     <= 1'b0;
								state_q   <= S_SW_RD;
							end
							CFG_RANKS: begin
								ranks_q <= cfg_data;
							end
							default: begin
							end
						endcase
					end else if (in_fire) begin
						if (s_axis_tuser == REQ_TICK) begin
							clock_q  <= clock_q + TIME_W'(s_axis_tdata[87:72]);
							idx_q    <= '0;
							report_q <= 1'b1;
							any_q    <= 1'b0;
							state_q  <= S_SW_RD;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (out_free) begin
						if (ram_we) begin
							valid_q[addr_q] <= 1'b1;
							class_q[addr_q] <= CLASS_FRESH;
						end
						o_accepted_q <= ram_we;
						o_changed_q  <= ram_we;
						if ((req_q == REQ_READ) && in_range_q && sel_valid) begin
							o_value_q  <= rd_entry.value;
							o_source_q <= rd_entry.writer;
							o_fresh_q  <= sel_class;
							o_age_q    <= age_res.age;
							o_set_q    <= 1'b1;
						end else begin
							o_value_q  <= '0;
							o_source_q <= '0;
							o_fresh_q  <= (req_q == REQ_READ) ? CLASS_INVALID : CLASS_FRESH;
							o_age_q    <= '0;
							o_set_q    <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_EVAL;
				end
				S_SW_EVAL: begin
					if (age_res.cls != sel_class) begin
						class_q[idx_q] <= age_res.cls;
						any_q          <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= report_q ? S_SW_OUT : S_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SW_RD;
					end
				end
				S_SW_OUT: begin
					if (out_free) begin
						o_accepted_q <= 1'b0;
						o_changed_q  <= any_q;
						o_value_q    <= '0;
						o_source_q   <= '0;
						o_fresh_q    <= CLASS_FRESH;
						o_age_q      <= '0;
						o_set_q      <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {o_set_q, o_age_q, o_fresh_q, o_source_q, o_value_q,
	                        o_changed_q, o_accepted_q};

endmodule

// ===== hw/rtl/psvs_slot_ram.sv =====
// ----------------------------------------------------------------------------
// psvs_slot_ram
// Slot payload memory: value, writer and timestamp, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module psvs_slot_ram
	import psvs_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int IDX_W = $clog2(NUM_SLOTS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  slot_entry_t      wdata,
	input  logic [IDX_W-1:0] raddr,
	output slot_entry_t      rdata
);

	slot_entry_t mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/psvs_age_unit.sv =====
// ----------------------------------------------------------------------------
// psvs_age_unit
// Shared age and freshness evaluator: one subtract and two compares against
// the stale and invalid limits.
// ----------------------------------------------------------------------------
module psvs_age_unit
	import psvs_pkg::*;
(
	input  logic [TIME_W-1:0] clock_ms,
	input  logic [TIME_W-1:0] stamp,
	input  logic              set,
	input  logic [CFG_W-1:0]  stale_ms,
	input  logic [CFG_W-1:0]  invalid_ms,
	output age_res_t          res
);

	logic [TIME_W:0] diff;
	logic            neg;
	logic            lt_stale;
	logic            lt_invalid;

	always_comb begin
		diff       = {1'b0, clock_ms} - {1'b0, stamp};
		neg        = diff[TIME_W];
		// A negative age is below every limit.
		lt_stale   = neg || (diff[TIME_W-1:0] < stale_ms);
		lt_invalid = neg || (diff[TIME_W-1:0] < invalid_ms);

		res.age          = neg ? '0 : diff[TIME_W-1:0];
		res.past_invalid = !lt_invalid;
		if (!set) begin
			res.cls = CLASS_INVALID;
		end else if (lt_stale) begin
			res.cls = CLASS_FRESH;
		end else if (lt_invalid) begin
			res.cls = CLASS_STALE;
		end else begin
			res.cls = CLASS_INVALID;
		end
	end

endmodule
